>>> design/frt_pkg.sv
package frt_pkg;

  // Field widths of the fragment descriptor and of the result.
  localparam int ADDR_W = 8;
  localparam int SRC_W  = 6;
  localparam int FID_W  = 3;
  localparam int LEN_W  = 16;
  localparam int SEQ_W  = 8;
  localparam int STAT_W = 3;

  // Fragment position codes, built as {is_first, is_last}.
  localparam logic [1:0] POS_WHOLE = 2'h3;
  localparam logic [1:0] POS_FIRST = 2'h2;
  localparam logic [1:0] POS_LAST  = 2'h1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_NOT_OURS = 3'd0;
  localparam logic [STAT_W-1:0] ST_WHOLE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_REASM    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROP     = 3'd3;
  localparam logic [STAT_W-1:0] ST_STORED   = 3'd4;

  // Classification of a fragment when it is accepted.
  localparam logic [1:0] KIND_NOT_OURS = 2'd0;
  localparam logic [1:0] KIND_WHOLE    = 2'd1;
  localparam logic [1:0] KIND_RANGE    = 2'd2;
  localparam logic [1:0] KIND_CTX      = 2'd3;

endpackage

>>> design/frt_if.sv
interface frt_frag_if;
  logic                         valid;
  logic                         ready;
  logic [frt_pkg::ADDR_W-1:0]   dest_address;
  logic [frt_pkg::SRC_W-1:0]    source_station;
  logic [frt_pkg::FID_W-1:0]    flow_id;
  logic                         is_first;
  logic                         is_last;
  logic [frt_pkg::LEN_W-1:0]    frag_length;
  logic [frt_pkg::SEQ_W-1:0]    seq_number;
  logic [frt_pkg::LEN_W-1:0]    packet_length;

  modport source (
    output valid, dest_address, source_station, flow_id, is_first, is_last,
           frag_length, seq_number, packet_length,
    input  ready
  );
  modport sink (
    input  valid, dest_address, source_station, flow_id, is_first, is_last,
           frag_length, seq_number, packet_length,
    output ready
  );
endinterface

interface frt_res_if;
  logic                         valid;
  logic                         ready;
  logic [frt_pkg::STAT_W-1:0]   status;
  logic                         stale_discarded;
  logic [frt_pkg::LEN_W-1:0]    assembled_length;

  modport source (
    output valid, status, stale_discarded, assembled_length,
    input  ready
  );
  modport sink (
    input  valid, status, stale_discarded, assembled_length,
    output ready
  );
endinterface

interface frt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [frt_pkg::ADDR_W-1:0]   data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

>>> design/frt_ram.sv
module frt_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 512
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write of the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/fragment_reassembly_tracker_top.sv
// Fragment reassembly tracker. Each fragment descriptor is checked against
// own_address, classified, and, when it belongs to a reassembly context
// (source_station * FLOW_IDS + flow_id), applied to that context in a
// single-port-read, single-port-write context memory. The block takes one
// fragment per cycle while results are taken; the context read is issued
// at the accepting clock edge, and the update is loaded into the result
// register when the read stage passes its fragment on. A fragment waits in the read
// stage while an unaccepted result holds the result register, and
// back-to-back fragments to the same context are served by forwarding the
// entry being written. After reset a clearing pass writes every one of the
// SOURCE_COUNT * FLOW_IDS contexts to zero, one per cycle, and no fragment
// is accepted during those cycles; writes of own_address are taken at any
// time.
module fragment_reassembly_tracker_top #(
  parameter int SOURCE_COUNT = 64,
  parameter int FLOW_IDS     = 8,
  parameter int SEQ_BITS     = 8
) (
  input logic          clk,
  input logic          rst,
  frt_frag_if.sink     frag,
  frt_res_if.source    res,
  frt_cfg_if.sink      cfg
);

  localparam int DEPTH = SOURCE_COUNT * FLOW_IDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (SEQ_BITS > frt_pkg::SEQ_W) ? SEQ_BITS : frt_pkg::SEQ_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef struct packed {
    logic                         pend;
    logic [frt_pkg::LEN_W-1:0]    len;
    logic [SEQ_BITS-1:0]          eseq;
  } ctx_t;

  // Configuration register.
  logic [frt_pkg::ADDR_W-1:0] own_address;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg.valid) begin
      own_address <= cfg.data;
    end
  end

  // Clearing pass after reset.
  logic          clearing;
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == LAST_IDX) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // Stage 1 holds the accepted fragment while the context is read.
  logic                         s1_valid;
  logic [1:0]                   s1_kind;
  logic [AW-1:0]                s1_addr;
  logic                         s1_first;
  logic                         s1_last;
  logic [frt_pkg::LEN_W-1:0]    s1_flen;
  logic [frt_pkg::SEQ_W-1:0]    s1_seq;
  logic [frt_pkg::LEN_W-1:0]    s1_tlen;

  logic s1_fire;
  logic frag_acc;

  assign s1_fire    = s1_valid && (!res.valid || res.ready);
  assign frag.ready = !clearing && (!s1_valid || s1_fire);
  assign frag_acc   = frag.valid && frag.ready;

  // Classification at acceptance.
  logic [1:0]    pos;
  logic          in_range;
  logic [AW-1:0] rd_addr;
  logic [1:0]    kind;

  assign pos      = {frag.is_first, frag.is_last};
  assign in_range = ({3'b000, frag.source_station} < 9'(SOURCE_COUNT)) &&
                    ({1'b0, frag.flow_id} < 4'(FLOW_IDS));
  // Modular arithmetic on AW bits is exact for every index below DEPTH.
  assign rd_addr  = AW'(frag.source_station) * AW'(FLOW_IDS) + AW'(frag.flow_id);

  always_comb begin
    if (frag.dest_address != own_address) begin
      kind = frt_pkg::KIND_NOT_OURS;
    end else if (pos == frt_pkg::POS_WHOLE) begin
      kind = frt_pkg::KIND_WHOLE;
    end else if (!in_range) begin
      kind = frt_pkg::KIND_RANGE;
    end else begin
      kind = frt_pkg::KIND_CTX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frag_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frag_acc) begin
      s1_kind  <= kind;
      s1_addr  <= rd_addr;
      s1_first <= frag.is_first;
      s1_last  <= frag.is_last;
      s1_flen  <= frag.frag_length;
      s1_seq   <= frag.seq_number;
      s1_tlen  <= frag.packet_length;
    end
  end

  // Context memory and forwarding of a same-cycle write.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ctx_t          wr_data;
  ctx_t          ram_rdata;
  logic          fwd_hit;
  ctx_t          fwd_data;
  ctx_t          ctx_new;

  assign wr_en   = clearing || (s1_fire && (s1_kind == frt_pkg::KIND_CTX));
  assign wr_addr = clearing ? clr_cnt : s1_addr;
  assign wr_data = clearing ? ctx_t'('0) : ctx_new;

  frt_ram #(
    .WIDTH ($bits(ctx_t)),
    .DEPTH (DEPTH)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (frag_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (frag_acc) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (frag_acc) begin
      fwd_data <= wr_data;
    end
  end

  // Context update.
  ctx_t                         ctx_cur;
  logic                         pend1;
  logic [SEQ_BITS-1:0]          eseq1;
  logic [frt_pkg::LEN_W-1:0]    len0;
  logic [frt_pkg::LEN_W:0]      sum;
  logic [frt_pkg::LEN_W-1:0]    len_sat;
  logic                         stale;
  logic                         match;
  logic [CW-1:0]                seq_inc;
  logic [frt_pkg::STAT_W-1:0]   ctx_status;

  assign ctx_cur = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    if (s1_first) begin
      stale = ctx_cur.pend;
      pend1 = 1'b1;
      len0  = '0;
      eseq1 = ctx_cur.pend ? (ctx_cur.eseq + SEQ_BITS'(1)) : ctx_cur.eseq;
    end else begin
      stale = 1'b0;
      pend1 = ctx_cur.pend;
      len0  = ctx_cur.len;
      eseq1 = ctx_cur.eseq;
    end
  end

  assign sum     = {1'b0, len0} + {1'b0, s1_flen};
  assign len_sat = sum[frt_pkg::LEN_W] ? '1 : sum[frt_pkg::LEN_W-1:0];
  assign match   = pend1 && (len_sat == s1_tlen) && (CW'(eseq1) == CW'(s1_seq));
  assign seq_inc = CW'(s1_seq) + CW'(1);

  always_comb begin
    if (s1_last) begin
      if (match) begin
        ctx_status   = frt_pkg::ST_REASM;
        ctx_new.pend = 1'b0;
        ctx_new.len  = '0;
        ctx_new.eseq = eseq1 + SEQ_BITS'(1);
      end else begin
        ctx_status   = frt_pkg::ST_DROP;
        ctx_new.pend = 1'b0;
        ctx_new.len  = len_sat;
        ctx_new.eseq = seq_inc[SEQ_BITS-1:0];
      end
    end else begin
      ctx_status   = pend1 ? frt_pkg::ST_STORED : frt_pkg::ST_DROP;
      ctx_new.pend = pend1;
      ctx_new.len  = len_sat;
      ctx_new.eseq = eseq1;
    end
  end

  // Result register.
  logic [frt_pkg::STAT_W-1:0] status_next;
  logic                       stale_next;
  logic [frt_pkg::LEN_W-1:0]  alen_next;

  always_comb begin
    case (s1_kind)
      frt_pkg::KIND_NOT_OURS: begin
        status_next = frt_pkg::ST_NOT_OURS;
        stale_next  = 1'b0;
        alen_next   = '0;
      end
      frt_pkg::KIND_WHOLE: begin
        status_next = frt_pkg::ST_WHOLE;
        stale_next  = 1'b0;
        alen_next   = s1_flen;
      end
      frt_pkg::KIND_CTX: begin
        status_next = ctx_status;
        stale_next  = stale;
        alen_next   = len_sat;
      end
      default: begin
        status_next = frt_pkg::ST_DROP;
        stale_next  = 1'b0;
        alen_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res.status           <= status_next;
      res.stale_discarded  <= stale_next;
      res.assembled_length <= alen_next;
    end
  end

  // Assertions.
  a_clear_runs: assert property (@(posedge clk) disable iff (rst)
    (clearing && (clr_cnt != LAST_IDX)) |=> clearing)
    else $error("clearing pass ended early");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res.valid && !res.ready) |-> !frag.ready)
    else $error("fragment accepted while the pipeline is blocked");

  a_reasm_not_stale: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == frt_pkg::ST_REASM)) |-> !res.stale_discarded)
    else $error("reassembled delivery flagged a stale discard");

  a_not_ours_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == frt_pkg::ST_NOT_OURS)) |->
      (!res.stale_discarded && (res.assembled_length == '0)))
    else $error("foreign fragment reported nonzero fields");

  a_ctx_write_on_fire: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !clearing) |=> res.valid)
    else $error("context written without a result");

endmodule
